// ===== hw/rtl/usb_ctdc_pkg.sv =====
// shared types, constants and descriptor flag helper for the control td chain builder
// no dependencies; imported by the controller, the datapath and the top level
package usb_ctdc_pkg;

  localparam int MAX_DESCRIPTORS_DEF = 64;

  // pid codes
  localparam logic [1:0] PID_SETUP = 2'd0;
  localparam logic [1:0] PID_OUT   = 2'd1;
  localparam logic [1:0] PID_IN    = 2'd2;

  // toggle codes as carried in the descriptor
  localparam logic [1:0] TOG_DATA0 = 2'd2;
  localparam logic [1:0] TOG_DATA1 = 2'd3;

  localparam logic [2:0] DELAY_NONE = 3'd7;
  localparam logic [2:0] DELAY_NOW  = 3'd0;

  localparam logic [7:0] MPS_LOW_DEF  = 8'd8;
  localparam logic [7:0] MPS_FULL_DEF = 8'd64;

  localparam logic [31:0] TD_STRIDE  = 32'd16;
  localparam logic [31:0] SETUP_LAST = 32'd7;

  // which descriptor the datapath builds on an emit
  typedef enum logic [1:0] {
    KIND_SETUP,
    KIND_DATA,
    KIND_STATUS,
    KIND_REJECT
  } emit_kind_t;

  typedef struct packed {
    logic       load;
    logic       emit;
    emit_kind_t kind;
  } ctdc_cmd_t;

  typedef struct packed {
    logic reject;
    logic no_data;
    logic data_last;
  } ctdc_status_t;

  // general td flags word: rounding, pid, delay interrupt, toggle
  function automatic logic [31:0] td_flags(input logic [1:0] pid, input logic [1:0] tog,
                                           input logic [2:0] delay, input logic rounding);
    logic [31:0] f;
    f = '0;
    f[18]    = rounding;
    f[20:19] = pid;
    f[23:21] = delay;
    f[25:24] = tog;
    return f;
  endfunction

endpackage

// ===== hw/rtl/usb_ctdc_ctrl.sv =====
// controller state machine of the control td chain builder
// depends on usb_ctdc_pkg; drives commands to usb_ctdc_datapath
module usb_ctdc_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  usb_ctdc_pkg::ctdc_status_t status,
  output usb_ctdc_pkg::ctdc_cmd_t    cmd
);
  import usb_ctdc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SETUP,
    ST_DATA,
    ST_STATUS,
    ST_REJECT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  // output register can take a new descriptor
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // command decode and next state
  always_comb begin
    cmd           = '0;
    cmd.kind      = KIND_SETUP;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = status.reject ? ST_REJECT : ST_SETUP;
      end
      ST_SETUP: begin
        cmd.kind = KIND_SETUP;
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = status.no_data ? ST_STATUS : ST_DATA;
        end
      end
      ST_DATA: begin
        cmd.kind = KIND_DATA;
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          if (status.data_last) state_nxt = ST_STATUS;
        end
      end
      ST_STATUS: begin
        cmd.kind = KIND_STATUS;
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_REJECT: begin
        cmd.kind = KIND_REJECT;
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hw/rtl/usb_ctdc_datapath.sv =====
// datapath of the control td chain builder: request registers, chunk walk, output register
// depends on usb_ctdc_pkg; commanded by usb_ctdc_ctrl
module usb_ctdc_datapath #(
  parameter int MAX_DESCRIPTORS = usb_ctdc_pkg::MAX_DESCRIPTORS_DEF
) (
  input  logic                       clk,
  input  usb_ctdc_pkg::ctdc_cmd_t    cmd,
  output usb_ctdc_pkg::ctdc_status_t status,
  input  logic [7:0]                 in_request_type,
  input  logic [15:0]                in_data_length,
  input  logic [7:0]                 in_max_packet_size,
  input  logic                       in_low_speed,
  input  logic [6:0]                 in_device_address,
  input  logic [31:0]                in_setup_buffer_address,
  input  logic [31:0]                in_data_buffer_address,
  input  logic [31:0]                in_descriptor_base_address,
  input  logic [31:0]                in_tail_address,
  output logic [31:0]                out_descriptor_flags,
  output logic [31:0]                out_buffer_start,
  output logic [31:0]                out_buffer_last,
  output logic [31:0]                out_next_descriptor,
  output logic [26:0]                out_endpoint_flags,
  output logic                       out_last_descriptor,
  output logic                       out_rejected
);
  import usb_ctdc_pkg::*;

  localparam int IDX_W  = $clog2(MAX_DESCRIPTORS + 1);
  localparam int LIMIT  = MAX_DESCRIPTORS - 2;
  localparam int PROD_W = 8 + IDX_W;
  localparam int CMP_W  = (PROD_W > 16) ? PROD_W : 16;

  // captured request
  logic        data_in_r;
  logic [15:0] dlen_r;
  logic [7:0]  mps_r;
  logic        ls_r;
  logic [6:0]  addr_r;
  logic [31:0] setup_a_r;
  logic [31:0] tail_r;

  // walking state
  logic [15:0] bytes_left_r;
  logic [31:0] cur_addr_r;
  logic [31:0] next_td_r;
  logic        toggle_data1_r;

  // output register
  logic [31:0] flags_r, start_r, last_r, next_r;
  logic [26:0] ep_r;
  logic        last_desc_r, rej_r;

  logic [7:0]        mps_eff;
  logic [PROD_W-1:0] lim_bytes;
  logic [15:0]       chunk;
  logic [26:0]       ep;
  logic [1:0]        data_pid;
  logic [1:0]        status_pid;

  // speed default for a zero max packet
  assign mps_eff = (in_max_packet_size != 8'd0) ? in_max_packet_size
                 : (in_low_speed ? MPS_LOW_DEF : MPS_FULL_DEF);

  // chain too long when data_length exceeds the allowed packets times max packet
  assign lim_bytes = PROD_W'(mps_r) * PROD_W'(LIMIT);
  assign status.reject    = CMP_W'(dlen_r) > CMP_W'(lim_bytes);
  assign status.no_data   = (bytes_left_r == 16'd0);
  assign status.data_last = (bytes_left_r <= {8'd0, mps_r});

  assign chunk      = status.data_last ? bytes_left_r : {8'd0, mps_r};
  assign ep         = {3'b000, mps_r, 2'b00, ls_r, 6'd0, addr_r};
  assign data_pid   = data_in_r ? PID_IN : PID_OUT;
  assign status_pid = (dlen_r != 16'd0 && !data_in_r) ? PID_IN
                    : ((dlen_r != 16'd0) ? PID_OUT : PID_IN);

  // request capture and per-descriptor updates
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_in_r      <= in_request_type[7];
      dlen_r         <= in_data_length;
      mps_r          <= mps_eff;
      ls_r           <= in_low_speed;
      addr_r         <= in_device_address;
      setup_a_r      <= in_setup_buffer_address;
      tail_r         <= in_tail_address;
      bytes_left_r   <= in_data_length;
      cur_addr_r     <= in_data_buffer_address;
      next_td_r      <= in_descriptor_base_address + TD_STRIDE;
      toggle_data1_r <= 1'b1;
    end else if (cmd.emit) begin
      case (cmd.kind)
        KIND_SETUP: next_td_r <= next_td_r + TD_STRIDE;
        KIND_DATA: begin
          next_td_r      <= next_td_r + TD_STRIDE;
          bytes_left_r   <= bytes_left_r - chunk;
          cur_addr_r     <= cur_addr_r + {16'd0, chunk};
          toggle_data1_r <= !toggle_data1_r;
        end
        default: ;
      endcase
    end
  end

  // descriptor build into the output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.kind)
        KIND_SETUP: begin
          flags_r     <= td_flags(PID_SETUP, TOG_DATA0, DELAY_NONE, 1'b0);
          start_r     <= setup_a_r;
          last_r      <= setup_a_r + SETUP_LAST;
          next_r      <= next_td_r;
          ep_r        <= ep;
          last_desc_r <= 1'b0;
          rej_r       <= 1'b0;
        end
        KIND_DATA: begin
          flags_r     <= td_flags(data_pid, toggle_data1_r ? TOG_DATA1 : TOG_DATA0,
                                  DELAY_NONE, data_in_r);
          start_r     <= cur_addr_r;
          last_r      <= cur_addr_r + {16'd0, chunk} - 32'd1;
          next_r      <= next_td_r;
          ep_r        <= ep;
          last_desc_r <= 1'b0;
          rej_r       <= 1'b0;
        end
        KIND_STATUS: begin
          flags_r     <= td_flags(status_pid, TOG_DATA1, DELAY_NOW, 1'b0);
          start_r     <= '0;
          last_r      <= '0;
          next_r      <= tail_r;
          ep_r        <= ep;
          last_desc_r <= 1'b1;
          rej_r       <= 1'b0;
        end
        default: begin
          flags_r     <= '0;
          start_r     <= '0;
          last_r      <= '0;
          next_r      <= '0;
          ep_r        <= '0;
          last_desc_r <= 1'b1;
          rej_r       <= 1'b1;
        end
      endcase
    end
  end

  assign out_descriptor_flags = flags_r;
  assign out_buffer_start     = start_r;
  assign out_buffer_last      = last_r;
  assign out_next_descriptor  = next_r;
  assign out_endpoint_flags   = ep_r;
  assign out_last_descriptor  = last_desc_r;
  assign out_rejected         = rej_r;

endmodule

// ===== hw/rtl/usb_control_td_chain_builder.sv =====
// Control-transfer td chain builder, top level.
// One transaction on the in_ channel carries a control request. The block answers
// with its chain of general transfer descriptors on the out_ channel, one transaction
// per descriptor: SETUP, then one data descriptor per max-packet chunk with toggle
// alternating from DATA1, then the zero-length status descriptor, flagged by
// out_last_descriptor. A chain longer than MAX_DESCRIPTORS gives one transaction
// with out_rejected and out_last_descriptor set and all other fields zero.
// Sequence: after the request is taken, the controller checks the chain length in its
// CHECK state, then emits one descriptor per cycle while the output register is free
// (out_valid low or out_ready high). The first descriptor passes the CHECK and SETUP
// states into the output register; no new request is taken until the last is emitted.
// in_ready is high only while no request is being walked.
// A stalled receiver holds the output register; the sequencer waits with it and
// resumes as soon as out_ready returns, losing nothing.
// Reset (rst_n low, synchronous) returns the controller to idle and drops out_valid.
// depends on usb_ctdc_pkg, usb_ctdc_ctrl and usb_ctdc_datapath
module usb_control_td_chain_builder #(
  parameter int MAX_DESCRIPTORS = usb_ctdc_pkg::MAX_DESCRIPTORS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_request_type,
  input  logic [15:0] in_data_length,
  input  logic [7:0]  in_max_packet_size,
  input  logic        in_low_speed,
  input  logic [6:0]  in_device_address,
  input  logic [31:0] in_setup_buffer_address,
  input  logic [31:0] in_data_buffer_address,
  input  logic [31:0] in_descriptor_base_address,
  input  logic [31:0] in_tail_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_descriptor_flags,
  output logic [31:0] out_buffer_start,
  output logic [31:0] out_buffer_last,
  output logic [31:0] out_next_descriptor,
  output logic [26:0] out_endpoint_flags,
  output logic        out_last_descriptor,
  output logic        out_rejected
);
  import usb_ctdc_pkg::*;

  ctdc_cmd_t    cmd;
  ctdc_status_t status;

  // sequencer
  usb_ctdc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // request registers and descriptor build
  usb_ctdc_datapath #(
    .MAX_DESCRIPTORS (MAX_DESCRIPTORS)
  ) u_datapath (
    .clk                        (clk),
    .cmd                        (cmd),
    .status                     (status),
    .in_request_type            (in_request_type),
    .in_data_length             (in_data_length),
    .in_max_packet_size         (in_max_packet_size),
    .in_low_speed               (in_low_speed),
    .in_device_address          (in_device_address),
    .in_setup_buffer_address    (in_setup_buffer_address),
    .in_data_buffer_address     (in_data_buffer_address),
    .in_descriptor_base_address (in_descriptor_base_address),
    .in_tail_address            (in_tail_address),
    .out_descriptor_flags       (out_descriptor_flags),
    .out_buffer_start           (out_buffer_start),
    .out_buffer_last            (out_buffer_last),
    .out_next_descriptor        (out_next_descriptor),
    .out_endpoint_flags         (out_endpoint_flags),
    .out_last_descriptor        (out_last_descriptor),
    .out_rejected               (out_rejected)
  );

endmodule

// ===== bench/tb_usb_control_td_chain_builder.sv =====
// self-checking bench for usb_control_td_chain_builder: control requests in, descriptor chains out
// depends on usb_ctdc_pkg and the block's rtl; needs nothing else
`timescale 1ns / 1ps

module tb_usb_control_td_chain_builder;
  import usb_ctdc_pkg::*;

  localparam int          N_DIRECTED = 19;
  localparam int          N_RANDOM   = 211;
  localparam int unsigned MAX_TD     = MAX_DESCRIPTORS_DEF;

  // one control request as presented on the in_ channel
  typedef struct packed {
    logic [7:0]  rtype;
    logic [15:0] dlen;
    logic [7:0]  mps;
    logic        ls;
    logic [6:0]  dev;
    logic [31:0] setup_a;
    logic [31:0] data_a;
    logic [31:0] base_a;
    logic [31:0] tail_a;
  } ctrl_req_t;

  // one descriptor as seen on the out_ channel
  typedef struct packed {
    logic [31:0] flags;
    logic [31:0] buf_start;
    logic [31:0] buf_last;
    logic [31:0] next_td;
    logic [26:0] ep_flags;
    logic        chain_end;
    logic        rejected;
  } td_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_REJECT,
    ROW_ZERO_REQUEST
  } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    ctrl_req_t req;
  } dir_row_t;

  // expected results typed in by hand
  localparam td_t TD_REJECTED   = '{32'h0, 32'h0, 32'h0, 32'h0, 27'h0, 1'b1, 1'b1};
  localparam td_t TD_ZERO_SETUP = '{32'h02E0_0000, 32'h0, 32'h7, 32'h10, 27'h040_0000,
                                    1'b0, 1'b0};
  localparam td_t TD_ZERO_STAT  = '{32'h0310_0000, 32'h0, 32'h0, 32'h0, 27'h040_0000,
                                    1'b1, 1'b0};

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_request_type;
  logic [15:0] in_data_length;
  logic [7:0]  in_max_packet_size;
  logic        in_low_speed;
  logic [6:0]  in_device_address;
  logic [31:0] in_setup_buffer_address;
  logic [31:0] in_data_buffer_address;
  logic [31:0] in_descriptor_base_address;
  logic [31:0] in_tail_address;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_descriptor_flags;
  logic [31:0] out_buffer_start;
  logic [31:0] out_buffer_last;
  logic [31:0] out_next_descriptor;
  logic [26:0] out_endpoint_flags;
  logic        out_last_descriptor;
  logic        out_rejected;

  td_t         td_expect_q[$];
  int unsigned n_errors;
  int unsigned n_seen;

  // directed requests: defaults, chain length limits, address wrap, toggles
  dir_row_t dir_table [N_DIRECTED] = '{
    '{ROW_ZERO_REQUEST, '{8'h00, 16'd0, 8'd0, 1'b0, 7'h00,
                          32'h0, 32'h0, 32'h0, 32'h0}},
    '{ROW_PREDICT, '{8'h80, 16'd0, 8'd0, 1'b1, 7'h01,
                     32'h0000_1000, 32'h0000_2000, 32'h0001_0000, 32'h0001_0400}},
    '{ROW_PREDICT, '{8'h80, 16'd8, 8'd0, 1'b1, 7'h7F,
                     32'h0000_1008, 32'h0000_3000, 32'h0002_0000, 32'h0002_0400}},
    '{ROW_PREDICT, '{8'h00, 16'd64, 8'd0, 1'b0, 7'h2A,
                     32'h1234_5678, 32'h8765_4320, 32'h0003_0000, 32'h0003_0400}},
    '{ROW_PREDICT, '{8'hFF, 16'd65, 8'd64, 1'b0, 7'h40,
                     32'h0000_0100, 32'h0000_0200, 32'h0004_0000, 32'h0004_0400}},
    '{ROW_PREDICT, '{8'h7F, 16'd1, 8'd1, 1'b0, 7'h03,
                     32'h0000_0110, 32'h0000_0300, 32'h0005_0000, 32'h0005_0400}},
    '{ROW_PREDICT, '{8'h80, 16'd62, 8'd1, 1'b0, 7'h04,
                     32'h0000_0120, 32'h0000_0400, 32'h0006_0000, 32'h0006_0400}},
    '{ROW_REJECT,  '{8'h80, 16'd63, 8'd1, 1'b0, 7'h05,
                     32'h0000_0130, 32'h0000_0500, 32'h0007_0000, 32'h0007_0400}},
    '{ROW_REJECT,  '{8'hFF, 16'hFFFF, 8'd255, 1'b1, 7'h7F,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    '{ROW_REJECT,  '{8'h00, 16'hFFFF, 8'd0, 1'b0, 7'h00,
                     32'h0, 32'h0, 32'h0, 32'h0}},
    '{ROW_PREDICT, '{8'hFF, 16'd15810, 8'd255, 1'b1, 7'h7F,
                     32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF}},
    '{ROW_REJECT,  '{8'h00, 16'd15811, 8'd255, 1'b0, 7'h11,
                     32'h0000_0140, 32'h0000_0600, 32'h0008_0000, 32'h0008_0400}},
    '{ROW_PREDICT, '{8'h80, 16'd496, 8'd0, 1'b1, 7'h22,
                     32'h0000_0150, 32'h0000_0700, 32'h0009_0000, 32'h0009_0400}},
    '{ROW_REJECT,  '{8'h80, 16'd497, 8'd0, 1'b1, 7'h33,
                     32'h0000_0160, 32'h0000_0800, 32'h000A_0000, 32'h000A_0400}},
    '{ROW_PREDICT, '{8'h00, 16'd3, 8'd2, 1'b0, 7'h44,
                     32'h0000_0170, 32'h0000_0900, 32'h000B_0000, 32'h000B_0400}},
    '{ROW_PREDICT, '{8'h80, 16'd255, 8'd255, 1'b0, 7'h66,
                     32'h0000_0180, 32'h0000_0A00, 32'h000C_0000, 32'h000C_0400}},
    '{ROW_PREDICT, '{8'h80, 16'd300, 8'd128, 1'b0, 7'h55,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAA0, 32'h5555_5550}},
    '{ROW_PREDICT, '{8'h00, 16'd4000, 8'd200, 1'b1, 7'h2A,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5550, 32'hAAAA_AAA0}},
    '{ROW_PREDICT, '{8'h21, 16'd1000, 8'd17, 1'b1, 7'h19,
                     32'h0000_0190, 32'hFFFF_FE00, 32'hFFFF_FC00, 32'h0000_0010}}
  };

  usb_control_td_chain_builder i_dut (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .in_valid                   (in_valid),
    .in_ready                   (in_ready),
    .in_request_type            (in_request_type),
    .in_data_length             (in_data_length),
    .in_max_packet_size         (in_max_packet_size),
    .in_low_speed               (in_low_speed),
    .in_device_address          (in_device_address),
    .in_setup_buffer_address    (in_setup_buffer_address),
    .in_data_buffer_address     (in_data_buffer_address),
    .in_descriptor_base_address (in_descriptor_base_address),
    .in_tail_address            (in_tail_address),
    .out_valid                  (out_valid),
    .out_ready                  (out_ready),
    .out_descriptor_flags       (out_descriptor_flags),
    .out_buffer_start           (out_buffer_start),
    .out_buffer_last            (out_buffer_last),
    .out_next_descriptor        (out_next_descriptor),
    .out_endpoint_flags         (out_endpoint_flags),
    .out_last_descriptor        (out_last_descriptor),
    .out_rejected               (out_rejected)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // general td flags word: rounding at 18, pid at 19, delay at 21, toggle at 24
  function automatic logic [31:0] pack_td_flags(input logic [1:0] pid, input logic [1:0] tog,
                                                input logic [2:0] delay, input logic rounding);
    return {6'd0, tog, delay, pid, rounding, 18'd0};
  endfunction

  // expected descriptor chain of one accepted request
  function automatic void predict_td_chain(input ctrl_req_t r);
    logic [7:0]  mps;
    logic [15:0] left;
    logic [15:0] offset;
    logic [15:0] chunk;
    logic        to_host;
    logic        data1;
    logic [26:0] ep;
    int unsigned packets;
    int unsigned k;
    td_t         td;
    mps = r.mps;
    if (mps == 8'd0) mps = r.ls ? MPS_LOW_DEF : MPS_FULL_DEF;
    packets = (r.dlen == 16'd0) ? 0 : (int'(r.dlen) + int'(mps) - 1) / int'(mps);
    if (packets + 2 > MAX_TD) begin
      td_expect_q.push_back(TD_REJECTED);
      return;
    end
    to_host     = r.rtype[7];
    ep          = '0;
    ep[6:0]     = r.dev;
    ep[13]      = r.ls;
    ep[26:16]   = {3'd0, mps};
    // setup stage over the 8-byte packet
    td = '{pack_td_flags(PID_SETUP, TOG_DATA0, DELAY_NONE, 1'b0), r.setup_a,
           r.setup_a + SETUP_LAST, r.base_a + TD_STRIDE, ep, 1'b0, 1'b0};
    td_expect_q.push_back(td);
    // data stage, one max-packet chunk per descriptor, toggle from DATA1
    k      = 1;
    left   = r.dlen;
    offset = 16'd0;
    data1  = 1'b1;
    while (left != 16'd0) begin
      chunk = (left > {8'd0, mps}) ? {8'd0, mps} : left;
      td = '{pack_td_flags(to_host ? PID_IN : PID_OUT, data1 ? TOG_DATA1 : TOG_DATA0,
                           DELAY_NONE, to_host),
             r.data_a + {16'd0, offset}, r.data_a + {16'd0, offset} + {16'd0, chunk} - 32'd1,
             r.base_a + TD_STRIDE * (k + 1), ep, 1'b0, 1'b0};
      td_expect_q.push_back(td);
      data1  = ~data1;
      left   = left - chunk;
      offset = offset + chunk;
      k++;
    end
    // status stage, opposite direction, IN when there is no data
    td = '{pack_td_flags((r.dlen != 16'd0 && to_host) ? PID_OUT : PID_IN, TOG_DATA1,
                         DELAY_NOW, 1'b0),
           32'd0, 32'd0, r.tail_a, ep, 1'b1, 1'b0};
    td_expect_q.push_back(td);
  endfunction

  // mostly well-formed chains with random content, some near the limit, some noise
  function automatic ctrl_req_t random_request();
    ctrl_req_t   r;
    int unsigned shape;
    int unsigned sel;
    int unsigned mps_eff;
    int unsigned packets;
    r.rtype   = 8'($urandom);
    r.dlen    = 16'($urandom);
    r.mps     = 8'($urandom);
    r.ls      = 1'($urandom);
    r.dev     = 7'($urandom);
    r.setup_a = $urandom;
    r.data_a  = $urandom;
    r.base_a  = $urandom;
    r.tail_a  = $urandom;
    shape = $urandom_range(0, 99);
    if (shape < 10) return r;
    sel = $urandom_range(0, 9);
    if (sel < 2) r.mps = 8'd0;
    else if (sel < 5) r.mps = 8'($urandom_range(1, 16));
    mps_eff = (r.mps == 8'd0) ? (r.ls ? 8 : 64) : int'(r.mps);
    if (shape < 16) packets = $urandom_range(MAX_TD - 1, MAX_TD + 2);
    else if (shape < 26) packets = $urandom_range(40, MAX_TD - 2);
    else packets = $urandom_range(0, 10);
    r.dlen = (packets == 0) ? 16'd0 :
             16'((packets - 1) * mps_eff + $urandom_range(1, mps_eff));
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    n_errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("descriptor %0d %s: got %h, want %h", n_seen, name, got, want));
  endtask

  // request sender, bursts of transactions with random gaps
  initial begin : stimulus
    ctrl_req_t   req;
    int unsigned burst_left;
    int unsigned gap;
    n_errors                   = 0;
    rst_n                      = 1'b0;
    in_valid                   = 1'b0;
    in_request_type            = '0;
    in_data_length             = '0;
    in_max_packet_size         = '0;
    in_low_speed               = 1'b0;
    in_device_address          = '0;
    in_setup_buffer_address    = '0;
    in_data_buffer_address     = '0;
    in_descriptor_base_address = '0;
    in_tail_address            = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    burst_left = 0;
    for (int i = 0; i < N_DIRECTED + N_RANDOM; i++) begin
      req = (i < N_DIRECTED) ? dir_table[i].req : random_request();
      // idle between bursts, sometimes not at all
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      in_valid                   <= 1'b1;
      in_request_type            <= req.rtype;
      in_data_length             <= req.dlen;
      in_max_packet_size         <= req.mps;
      in_low_speed               <= req.ls;
      in_device_address          <= req.dev;
      in_setup_buffer_address    <= req.setup_a;
      in_data_buffer_address     <= req.data_a;
      in_descriptor_base_address <= req.base_a;
      in_tail_address            <= req.tail_a;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      // transaction taken at this edge
      if (i < N_DIRECTED && dir_table[i].kind == ROW_REJECT) begin
        td_expect_q.push_back(TD_REJECTED);
      end else if (i < N_DIRECTED && dir_table[i].kind == ROW_ZERO_REQUEST) begin
        td_expect_q.push_back(TD_ZERO_SETUP);
        td_expect_q.push_back(TD_ZERO_STAT);
      end else begin
        predict_td_chain(req);
      end
    end
    in_valid <= 1'b0;
    // drain, then keep watching for stray output before finishing
    while (td_expect_q.size() != 0) @(posedge clk);
    repeat (MAX_TD + 4) @(posedge clk);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // receiver, stalls on a rotating pattern reloaded now and then
  initial begin : receiver
    logic [15:0] pattern;
    out_ready = 1'b0;
    forever begin
      pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
      repeat ($urandom_range(20, 60)) begin
        @(posedge clk);
        out_ready <= pattern[0];
        pattern = {pattern[0], pattern[15:1]};
      end
    end
  end

  // compare each descriptor transaction with the oldest expectation
  always @(posedge clk) begin : check_descriptors
    td_t want;
    if (rst_n && out_valid && out_ready) begin
      if (td_expect_q.size() == 0) begin
        report_mismatch($sformatf("descriptor %0d unexpected, flags %h", n_seen,
                                  out_descriptor_flags));
      end else begin
        want = td_expect_q.pop_front();
        check_field("descriptor_flags", out_descriptor_flags, want.flags);
        check_field("buffer_start", out_buffer_start, want.buf_start);
        check_field("buffer_last", out_buffer_last, want.buf_last);
        check_field("next_descriptor", out_next_descriptor, want.next_td);
        check_field("endpoint_flags", {5'd0, out_endpoint_flags}, {5'd0, want.ep_flags});
        check_field("last_descriptor", {31'd0, out_last_descriptor}, {31'd0, want.chain_end});
        check_field("rejected", {31'd0, out_rejected}, {31'd0, want.rejected});
      end
      n_seen++;
    end
  end

  initial n_seen = 0;

  // watchdog
  initial begin : watchdog
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
